>>> rtl/rvx_pkg.sv
// Shared types and constants for the RV64IM integer execute unit.
// Used by rvx_cell and rv64im_integer_execute_unit.
package rvx_pkg;
   localparam int XLEN = 64;

   localparam logic [1:0] CLASS_OP     = 2'd0;
   localparam logic [1:0] CLASS_OP32   = 2'd1;
   localparam logic [1:0] CLASS_IMM    = 2'd2;
   localparam logic [1:0] CLASS_IMM32  = 2'd3;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SRL  = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   localparam logic [2:0] F3_MUL    = 3'd0;
   localparam logic [2:0] F3_MULH   = 3'd1;
   localparam logic [2:0] F3_MULHSU = 3'd2;
   localparam logic [2:0] F3_MULHU  = 3'd3;
   localparam logic [2:0] F3_DIV    = 3'd4;
   localparam logic [2:0] F3_DIVU   = 3'd5;
   localparam logic [2:0] F3_REM    = 3'd6;
   localparam logic [2:0] F3_REMU   = 3'd7;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_MULDIV = 7'h01;
   localparam logic [6:0] F7_ALT  = 7'h20;

   typedef enum logic [1:0] {
      K_ALU = 2'd0,
      K_MUL = 2'd1,
      K_DIV = 2'd2
   } kind_type;

   // Item that travels down the row of cells.
   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic        word;
      logic        illegal;
      logic [2:0]  f3;
      logic        neg_q;      // negate quotient at the end
      logic        neg_r;      // negate remainder at the end
      logic        div_zero;
      logic [63:0] fixed;      // finished value for ALU ops / special cases
      logic        use_fixed;
      logic [63:0] dvd;        // dividend shift register (quotient fills in)
      logic [63:0] dvs;        // divisor magnitude
      logic [64:0] rem;        // partial remainder
      logic [63:0] ma;         // multiplicand
      logic [63:0] mb;         // multiplier (shifted down)
      logic [127:0] acc;       // product accumulator
   } item_type;

   localparam int DIV_BITS  = 4;            // quotient bits per cell
   localparam int MUL_BITS  = 16;           // multiplier bits per cell
   localparam int NUM_CELLS = XLEN / DIV_BITS;

   function automatic logic [63:0] sx32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction
endpackage

>>> rtl/rvx_cell.sv
// One execute-row cell: retires DIV_BITS quotient bits of a divide item or
// MUL_BITS multiplier bits of a multiply item, then hands it on. Uses rvx_pkg.
module rvx_cell (
   input  logic              clock,
   input  logic              reset,
   input  rvx_pkg::item_type item_in,
   output rvx_pkg::item_type item_out
);
   import rvx_pkg::*;

   item_type item_ff, item_in_c;
   logic [64:0] r;
   logic [63:0] q;
   logic [64:0] diff;
   logic [127:0] acc;
   logic [63:0] mb;
   logic [79:0] part;

   always_comb begin
      item_in_c = item_in;
      r = item_in.rem;
      q = item_in.dvd;
      diff = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         r = {r[63:0], q[63]};
         q = {q[62:0], 1'b0};
         diff = r - {1'b0, item_in.dvs};
         if (!diff[64]) begin
            r = diff;
            q[0] = 1'b1;
         end
      end
      // one 64x16 partial product, added at its weight
      part = item_in.ma * item_in.mb[MUL_BITS-1:0];
      acc  = item_in.acc + {48'd0, part};
      mb   = {16'd0, item_in.mb[63:16]};
      if (item_in.kind == K_DIV) begin
         item_in_c.rem = r;
         item_in_c.dvd = q;
      end
      if (item_in.kind == K_MUL) begin
         item_in_c.acc = {acc[15:0], acc[127:16]};
         item_in_c.mb  = mb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
      end
      item_ff.kind      <= item_in_c.kind;
      item_ff.word      <= item_in_c.word;
      item_ff.illegal   <= item_in_c.illegal;
      item_ff.f3        <= item_in_c.f3;
      item_ff.neg_q     <= item_in_c.neg_q;
      item_ff.neg_r     <= item_in_c.neg_r;
      item_ff.div_zero  <= item_in_c.div_zero;
      item_ff.fixed     <= item_in_c.fixed;
      item_ff.use_fixed <= item_in_c.use_fixed;
      item_ff.dvd       <= item_in_c.dvd;
      item_ff.dvs       <= item_in_c.dvs;
      item_ff.rem       <= item_in_c.rem;
      item_ff.ma        <= item_in_c.ma;
      item_ff.mb        <= item_in_c.mb;
      item_ff.acc       <= item_in_c.acc;
   end

   assign item_out = item_ff;
endmodule

>>> rtl/rv64im_integer_execute_unit.sv
// RV64IM integer execute unit: top level with decode, the row of cells and
// the output stage. Uses rvx_pkg and rvx_cell.
//
// Usage:
//   Drive req_type, req_funct3, req_funct7, req_operand_a and req_operand_b
//   with start high; the item is taken at that edge. busy is always low,
//   so one item can be started in every cycle.
//   The result comes out on rsp_result and rsp_illegal with rsp_valid high
//   for exactly one cycle; every operation passes the decode register, the
//   row of cells and the output register, so results leave in start order.
//   The row length is set by the divider: each of the 16 cells retires four
//   quotient bits; the multiplier takes its nonzero 64x16 partial products
//   from the first four cells, and the others add zero and rotate the accumulator.
//   Throughput: one item per cycle.
//   Reset clears every valid flag in the row; items in flight are dropped.
//   The receiver cannot stall; rsp_valid is a strobe.
module rv64im_integer_execute_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [2:0]  req_funct3,
   input  logic [6:0]  req_funct7,
   input  logic [63:0] req_operand_a,
   input  logic [63:0] req_operand_b,
   output logic        rsp_valid,
   output logic [63:0] rsp_result,
   output logic        rsp_illegal
);
   import rvx_pkg::*;

   item_type dec_c, dec_ff;
   item_type row [NUM_CELLS+1];

   logic        bad, word, alt, is_md;
   logic [5:0]  sh;
   logic [63:0] p, q, alu, pw_s, qw_s, up, uq;
   logic        sgn, np, nq;
   logic [64:0] sra_src;

   assign busy = 1'b0;

   always_comb begin
      p = req_operand_a;
      q = req_operand_b;
      bad = 1'b0;
      is_md = 1'b0;
      word = req_type[0];
      alt = req_funct7[5];
      case (req_type)
         CLASS_OP: begin
            if (req_funct7 == F7_MULDIV) is_md = 1'b1;
            else if (req_funct7 == F7_BASE) ;
            else if (req_funct7 == F7_ALT &&
                     (req_funct3 == F3_ADD || req_funct3 == F3_SRL)) ;
            else bad = 1'b1;
         end
         CLASS_OP32: begin
            if (req_funct7 == F7_MULDIV)
               if (req_funct3 == F3_MUL || req_funct3[2]) is_md = 1'b1;
               else bad = 1'b1;
            else if ((req_funct7 == F7_BASE && (req_funct3 == F3_ADD ||
                      req_funct3 == F3_SLL || req_funct3 == F3_SRL)) ||
                     (req_funct7 == F7_ALT && (req_funct3 == F3_ADD ||
                      req_funct3 == F3_SRL))) ;
            else bad = 1'b1;
         end
         CLASS_IMM: begin
            if (req_funct3 == F3_SLL) bad = req_funct7[6:1] != 6'd0;
            else if (req_funct3 == F3_SRL)
               bad = req_funct7[6:1] != 6'd0 && req_funct7[6:1] != 6'd16;
            if (req_funct3 == F3_ADD) alt = 1'b0;
         end
         default: begin
            if (req_funct3 == F3_ADD) alt = 1'b0;
            else if (req_funct3 == F3_SLL && req_funct7 == F7_BASE) ;
            else if (req_funct3 == F3_SRL &&
                     (req_funct7 == F7_BASE || req_funct7 == F7_ALT)) ;
            else bad = 1'b1;
         end
      endcase

      // plain ALU
      sh = word ? {1'b0, q[4:0]} : q[5:0];
      if (word) begin
         sra_src = {{33{p[31]}}, p[31:0]};
         if (!alt) sra_src = {33'd0, p[31:0]};
      end else begin
         sra_src = {alt & p[63], p};
      end
      case (req_funct3)
         F3_ADD:  alu = alt ? p - q : p + q;
         F3_SLL:  alu = p << sh;
         F3_SLT:  alu = {63'd0, $signed(p) < $signed(q)};
         F3_SLTU: alu = {63'd0, p < q};
         F3_XOR:  alu = p ^ q;
         F3_SRL:  alu = 64'($signed(sra_src) >>> sh);
         F3_OR:   alu = p | q;
         default: alu = p & q;
      endcase
      if (word) alu = sx32(alu[31:0]);

      // multiply/divide operand preparation
      pw_s = word ? sx32(p[31:0]) : p;
      qw_s = word ? sx32(q[31:0]) : q;
      sgn = req_funct3 == F3_DIV || req_funct3 == F3_REM;
      np = sgn & pw_s[63];
      nq = sgn & qw_s[63];
      up = word ? (sgn ? pw_s : {32'd0, p[31:0]}) : p;
      uq = word ? (sgn ? qw_s : {32'd0, q[31:0]}) : q;
      if (np) up = -up;
      if (nq) uq = -uq;

      dec_c = '0;
      dec_c.valid = start;
      dec_c.word = word;
      dec_c.illegal = bad;
      dec_c.f3 = req_funct3;
      dec_c.kind = K_ALU;
      dec_c.use_fixed = 1'b1;
      dec_c.fixed = bad ? 64'd0 : alu;
      if (!bad && is_md) begin
         dec_c.use_fixed = 1'b0;
         if (req_funct3[2]) begin
            dec_c.kind = K_DIV;
            dec_c.dvd = up;
            dec_c.dvs = uq;
            dec_c.neg_q = np ^ nq;
            dec_c.neg_r = np;
            dec_c.div_zero = uq == 64'd0;
            // divide by zero: quotient all ones, remainder the dividend
            if (uq == 64'd0) begin
               dec_c.use_fixed = 1'b1;
               dec_c.fixed = req_funct3[1] ? pw_s : '1;
               if (word && req_funct3[1]) dec_c.fixed = sx32(p[31:0]);
            end
         end else begin
            dec_c.kind = K_MUL;
            dec_c.ma = p;
            dec_c.mb = q;
            // carry the whole multiplier along for the signed correction
            dec_c.dvs = q;
            dec_c.neg_q = (req_funct3 == F3_MULH || req_funct3 == F3_MULHSU) & p[63];
            dec_c.neg_r = (req_funct3 == F3_MULH) & q[63];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff.valid <= 1'b0;
      end else begin
         dec_ff.valid <= dec_c.valid;
      end
      dec_ff.kind      <= dec_c.kind;
      dec_ff.word      <= dec_c.word;
      dec_ff.illegal   <= dec_c.illegal;
      dec_ff.f3        <= dec_c.f3;
      dec_ff.neg_q     <= dec_c.neg_q;
      dec_ff.neg_r     <= dec_c.neg_r;
      dec_ff.div_zero  <= dec_c.div_zero;
      dec_ff.fixed     <= dec_c.fixed;
      dec_ff.use_fixed <= dec_c.use_fixed;
      dec_ff.dvd       <= dec_c.dvd;
      dec_ff.dvs       <= dec_c.dvs;
      dec_ff.rem       <= dec_c.rem;
      dec_ff.ma        <= dec_c.ma;
      dec_ff.mb        <= dec_c.mb;
      dec_ff.acc       <= dec_c.acc;
   end

   assign row[0] = dec_ff;

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      rvx_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .item_in  (row[g]),
         .item_out (row[g+1])
      );
   end

   item_type    fin;
   logic [63:0] quo, rmd, hi, fix, res_in;
   logic        rsp_valid_ff;
   logic [63:0] rsp_result_ff;
   logic        rsp_illegal_ff;

   always_comb begin
      fin = row[NUM_CELLS];
      // the accumulator rotated 16 bits per cell through all 16 cells
      hi  = fin.acc[127:64];
      // signed correction for MULH / MULHSU
      fix = (fin.neg_q ? fin.dvs : 64'd0);
      quo = fin.neg_q ? -fin.dvd : fin.dvd;
      rmd = fin.neg_r ? -fin.rem[63:0] : fin.rem[63:0];
      case (fin.kind)
         K_DIV:   res_in = fin.f3[1] ? rmd : quo;
         K_MUL:   res_in = fin.f3 == F3_MUL ? fin.acc[63:0] : hi - fix;
         default: res_in = fin.fixed;
      endcase
      if (fin.kind == K_MUL && fin.neg_r) res_in = res_in - fin.ma;
      if (fin.kind != K_ALU && fin.word) res_in = sx32(res_in[31:0]);
      if (fin.use_fixed) res_in = fin.fixed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin.valid;
      end
      rsp_result_ff  <= res_in;
      rsp_illegal_ff <= fin.illegal;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_result  = rsp_result_ff;
   assign rsp_illegal = rsp_illegal_ff;
endmodule

>>> tb/tb.sv
// Self-checking testbench for rv64im_integer_execute_unit.
// Drives register and immediate integer ops, predicts each result and
// compares in order; depends on rvx_pkg.
`timescale 1ns / 1ps

module tb;
   import rvx_pkg::*;

   localparam int LATENCY     = 18;
   localparam int NUM_RANDOM  = 1550;
   localparam int IDLE_LIMIT  = 400;

   typedef struct {
      logic [1:0]  kind;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [63:0] a;
      logic [63:0] b;
      logic        known;     // expected value typed in below
      logic [63:0] want;
      logic        want_bad;
   } stim_row_type;

   typedef struct {
      logic [63:0] value;
      logic        bad;
   } alu_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = '0;
   logic [2:0]  req_funct3 = '0;
   logic [6:0]  req_funct7 = '0;
   logic [63:0] req_operand_a = '0;
   logic [63:0] req_operand_b = '0;
   logic        rsp_valid;
   logic [63:0] rsp_result;
   logic        rsp_illegal;

   alu_out_type pending_results[$];
   int       errors = 0;
   int       idle_cycles = 0;

   rv64im_integer_execute_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_funct3(req_funct3), .req_funct7(req_funct7),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_result(rsp_result), .rsp_illegal(rsp_illegal)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] sext_word(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   // signed 64-bit divide with RISC-V corner cases
   function automatic logic [63:0] sdiv(input logic [63:0] p, input logic [63:0] q,
                                        input logic want_rem);
      logic [63:0] up, uq, r;
      up = p[63] ? -p : p;
      uq = q[63] ? -q : q;
      if (q == 0) return want_rem ? p : '1;
      if (want_rem) begin
         r = up % uq;
         return p[63] ? -r : r;
      end
      r = up / uq;
      return (p[63] != q[63]) ? -r : r;
   endfunction

   function automatic logic [63:0] base_op(input logic [2:0] f3, input logic alt,
                                           input logic [63:0] p, input logic [63:0] q);
      case (f3)
         F3_ADD:  return alt ? p - q : p + q;
         F3_SLL:  return p << q[5:0];
         F3_SLT:  return {63'd0, $signed(p) < $signed(q)};
         F3_SLTU: return {63'd0, p < q};
         F3_XOR:  return p ^ q;
         F3_SRL:  return alt ? 64'($signed(p) >>> q[5:0]) : p >> q[5:0];
         F3_OR:   return p | q;
         default: return p & q;
      endcase
   endfunction

   function automatic logic [63:0] muldiv_op(input logic [2:0] f3,
                                             input logic [63:0] p, input logic [63:0] q);
      logic [127:0] prod;
      case (f3)
         F3_MUL:    return p * q;
         F3_MULH:   begin
            prod = $signed({{64{p[63]}}, p}) * $signed({{64{q[63]}}, q});
            return prod[127:64];
         end
         F3_MULHSU: begin
            prod = {{64{p[63]}}, p} * {64'd0, q};
            return prod[127:64];
         end
         F3_MULHU:  begin
            prod = {64'd0, p} * {64'd0, q};
            return prod[127:64];
         end
         F3_DIV:    return sdiv(p, q, 1'b0);
         F3_DIVU:   return q == 0 ? '1 : p / q;
         F3_REM:    return sdiv(p, q, 1'b1);
         default:   return q == 0 ? p : p % q;
      endcase
   endfunction

   function automatic logic [63:0] word_op(input logic [2:0] f3, input logic alt,
                                           input logic [63:0] p, input logic [63:0] q);
      logic [31:0] pw, qw;
      pw = p[31:0];
      qw = q[31:0];
      case (f3)
         F3_ADD:  return sext_word(alt ? pw - qw : pw + qw);
         F3_SLL:  return sext_word(pw << q[4:0]);
         default: return alt ? sext_word(32'($signed(pw) >>> q[4:0]))
                             : sext_word(pw >> q[4:0]);
      endcase
   endfunction

   function automatic logic [63:0] muldiv_word(input logic [2:0] f3,
                                               input logic [63:0] p, input logic [63:0] q);
      logic [31:0] pw, qw;
      pw = p[31:0];
      qw = q[31:0];
      case (f3)
         F3_MUL:  return sext_word(pw * qw);
         F3_DIV:  return qw == 0 ? '1
                       : sext_word(32'(sdiv(sext_word(pw), sext_word(qw), 1'b0)));
         F3_DIVU: return qw == 0 ? '1 : sext_word(pw / qw);
         F3_REM:  return qw == 0 ? sext_word(pw)
                       : sext_word(32'(sdiv(sext_word(pw), sext_word(qw), 1'b1)));
         default: return qw == 0 ? sext_word(pw) : sext_word(pw % qw);
      endcase
   endfunction

   function automatic alu_out_type predict_execute(input logic [1:0] kind,
                                                   input logic [2:0] f3,
                                                   input logic [6:0] f7,
                                                   input logic [63:0] p,
                                                   input logic [63:0] q);
      alu_out_type o;
      o.bad = 1'b0;
      o.value = '0;
      case (kind)
         CLASS_OP: begin
            if (f7 == F7_MULDIV) o.value = muldiv_op(f3, p, q);
            else if (f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SRL)))
               o.value = base_op(f3, f7[5], p, q);
            else o.bad = 1'b1;
         end
         CLASS_OP32: begin
            if (f7 == F7_MULDIV) begin
               if (f3 == F3_MUL || f3 >= F3_DIV) o.value = muldiv_word(f3, p, q);
               else o.bad = 1'b1;
            end else if ((f7 == F7_BASE && (f3 == F3_ADD || f3 == F3_SLL || f3 == F3_SRL)) ||
                         (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SRL)))
               o.value = word_op(f3, f7[5], p, q);
            else o.bad = 1'b1;
         end
         CLASS_IMM: begin
            if (f3 == F3_SLL) o.bad = f7[6:1] != 0;
            else if (f3 == F3_SRL) o.bad = f7[6:1] != 0 && f7[6:1] != 6'd16;
            if (!o.bad) o.value = base_op(f3, f3 == F3_ADD ? 1'b0 : f7[5], p, q);
         end
         default: begin
            if (f3 == F3_ADD) o.value = word_op(F3_ADD, 1'b0, p, q);
            else if (f3 == F3_SLL && f7 == F7_BASE) o.value = word_op(F3_SLL, 1'b0, p, q);
            else if (f3 == F3_SRL && (f7 == F7_BASE || f7 == F7_ALT))
               o.value = word_op(F3_SRL, f7[5], p, q);
            else o.bad = 1'b1;
         end
      endcase
      if (o.bad) o.value = '0;
      return o;
   endfunction

   // Result checker and watchdog
   always @(posedge clock) begin
      alu_out_type exp_r;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result %h", rsp_result);
               errors++;
            end else begin
               exp_r = pending_results.pop_front();
               if (rsp_result !== exp_r.value) begin
                  $error("rsp_result expected %h actual %h", exp_r.value, rsp_result);
                  errors++;
               end
               if (rsp_illegal !== exp_r.bad) begin
                  $error("rsp_illegal expected %b actual %b", exp_r.bad, rsp_illegal);
                  errors++;
               end
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Present one item; hold until taken at a rising edge.
   task automatic issue_op(input logic [1:0] kind, input logic [2:0] f3, input logic [6:0] f7,
                           input logic [63:0] p, input logic [63:0] q,
                           input logic known, input logic [63:0] want, input logic want_bad);
      alu_out_type e;
      e = predict_execute(kind, f3, f7, p, q);
      if (known) begin
         e.value = want;
         e.bad = want_bad;
      end
      start <= 1'b1;
      req_type <= kind;
      req_funct3 <= f3;
      req_funct7 <= f7;
      req_operand_a <= p;
      req_operand_b <= q;
      do @(posedge clock); while (busy);
      pending_results.push_back(e);
      @(negedge clock);
   endtask

   task automatic pause_sender(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   function automatic logic [63:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return 64'h8000_0000_0000_0000;
         1: return '1;
         2: return 64'($urandom_range(0, 70));
         3: return sext_word($urandom);
         4: return {32'd0, $urandom};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [6:0] rand_funct7();
      case ($urandom_range(0, 9))
         0, 1, 2: return F7_BASE;
         3, 4, 5: return F7_MULDIV;
         6, 7:    return F7_ALT;
         8:       return 7'h21;
         default: return 7'($urandom);
      endcase
   endfunction

   stim_row_type directed[] = '{
      '{CLASS_OP,    F3_ADD,  F7_BASE,   '1, 64'd1, 1'b1, 64'd0, 1'b0},
      '{CLASS_OP,    F3_ADD,  F7_ALT,    64'd0, 64'd1, 1'b1, '1, 1'b0},
      '{CLASS_OP,    F3_SLL,  F7_BASE,   64'd1, 64'd127, 1'b1, 64'h8000_0000_0000_0000, 1'b0},
      '{CLASS_OP,    F3_SLT,  F7_BASE,   64'h8000_0000_0000_0000, 64'd0, 1'b1, 64'd1, 1'b0},
      '{CLASS_OP,    F3_SLTU, F7_BASE,   64'h8000_0000_0000_0000, 64'd0, 1'b1, 64'd0, 1'b0},
      '{CLASS_OP,    F3_XOR,  F7_BASE,   '1, 64'h5555, 1'b0, 0, 0},
      '{CLASS_OP,    F3_SRL,  F7_ALT,    64'h8000_0000_0000_0000, 64'd63, 1'b1, '1, 1'b0},
      '{CLASS_OP,    F3_OR,   F7_BASE,   64'h1234, 64'hF000_0000_0000_0000, 1'b0, 0, 0},
      '{CLASS_OP,    F3_AND,  F7_BASE,   '1, 64'hABCD, 1'b0, 0, 0},
      '{CLASS_OP,    F3_MUL,  F7_MULDIV, '1, '1, 1'b1, 64'd1, 1'b0},
      '{CLASS_OP,    F3_MULH, F7_MULDIV, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
        1'b1, 64'h4000_0000_0000_0000, 1'b0},
      '{CLASS_OP,    F3_MULHSU, F7_MULDIV, '1, '1, 1'b1, '1, 1'b0},
      '{CLASS_OP,    F3_MULHU, F7_MULDIV, '1, '1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0},
      '{CLASS_OP,    F3_DIV,  F7_MULDIV, 64'd7, 64'd0, 1'b1, '1, 1'b0},
      '{CLASS_OP,    F3_DIV,  F7_MULDIV, 64'h8000_0000_0000_0000, '1,
        1'b1, 64'h8000_0000_0000_0000, 1'b0},
      '{CLASS_OP,    F3_REM,  F7_MULDIV, 64'h8000_0000_0000_0000, '1, 1'b1, 64'd0, 1'b0},
      '{CLASS_OP,    F3_REMU, F7_MULDIV, 64'd9, 64'd0, 1'b1, 64'd9, 1'b0},
      '{CLASS_OP,    F3_DIVU, F7_MULDIV, '1, 64'd0, 1'b1, '1, 1'b0},
      '{CLASS_OP32,  F3_DIV,  F7_MULDIV, 64'h8000_0000, 64'hFFFF_FFFF,
        1'b1, 64'hFFFF_FFFF_8000_0000, 1'b0},
      '{CLASS_OP32,  F3_REM,  F7_MULDIV, 64'h1_8000_0000, 64'd0,
        1'b1, 64'hFFFF_FFFF_8000_0000, 1'b0},
      '{CLASS_OP32,  F3_ADD,  F7_BASE,   64'h7FFF_FFFF, 64'd1, 1'b1, 64'hFFFF_FFFF_8000_0000, 1'b0},
      '{CLASS_OP32,  F3_SLT,  F7_BASE,   64'd1, 64'd2, 1'b1, 64'd0, 1'b1},
      '{CLASS_IMM,   F3_SRL,  7'h21,     '1, 64'd4, 1'b1, '1, 1'b0},
      '{CLASS_IMM,   F3_SLL,  7'h7F,     64'd1, 64'd1, 1'b1, 64'd0, 1'b1},
      '{CLASS_IMM32, F3_SRL,  F7_ALT,    64'h8000_0000, 64'd31, 1'b1, '1, 1'b0}
   };

   initial begin
      logic [1:0] kind;
      logic [2:0] f3;
      logic [6:0] f7;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         issue_op(directed[i].kind, directed[i].f3, directed[i].f7, directed[i].a,
                  directed[i].b, directed[i].known, directed[i].want, directed[i].want_bad);

      for (int n = 0; n < NUM_RANDOM; n++) begin
         kind = 2'($urandom);
         f3 = 3'($urandom);
         f7 = rand_funct7();
         if (n == NUM_RANDOM / 2) begin
            // drain the pipe once before carrying on
            start <= 1'b0;
            while (pending_results.size() != 0) @(negedge clock);
         end
         // idle a random number of cycles before each item
         pause_sender($urandom_range(0, 6));
         issue_op(kind, f3, f7, rand_operand(), rand_operand(), 1'b0, '0, 1'b0);
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
